// ===== hdl/tcre_pkg.sv =====
`default_nettype none

package tcre_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam logic [15:0] SERVER_PORT = 16'd69;
   localparam logic [15:0] DEFAULT_BLOCK = 16'd512;
   localparam logic [7:0] DEFAULT_RETRIES = 8'd10;

   localparam logic [1:0] OPCODE_START = 2'd0;
   localparam logic [1:0] OPCODE_PACKET = 2'd1;
   localparam logic [1:0] OPCODE_TIMEOUT = 2'd2;

   localparam logic [15:0] TFTP_OP_DATA = 16'd3;
   localparam logic [15:0] TFTP_OP_ERROR = 16'd5;
   localparam logic [15:0] TFTP_OP_OACK = 16'd6;

   localparam logic [15:0] ERR_CODE_NOT_FOUND = 16'd1;
   localparam logic [15:0] ERR_CODE_ACCESS = 16'd2;

   localparam logic [15:0] MIN_PACKET_LEN = 16'd2;
   localparam logic [15:0] DATA_HEADER_LEN = 16'd4;

   localparam logic [1:0] SEND_NONE = 2'd0;
   localparam logic [1:0] SEND_RRQ = 2'd1;
   localparam logic [1:0] SEND_ACK = 2'd2;

   localparam logic [1:0] STATUS_RUNNING = 2'd0;
   localparam logic [1:0] STATUS_DONE = 2'd1;
   localparam logic [1:0] STATUS_FAILED = 2'd2;
   localparam logic [1:0] STATUS_RESTART = 2'd3;

   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RETRY_LIMIT = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOAD_BASE = 1'd1;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [11:0] local_port;
      logic [15:0] dest_port;
      logic [15:0] src_port;
      logic [15:0] udp_len;
      logic [15:0] tftp_op;
      logic [15:0] block_or_code;
      logic        has_blksize;
      logic [15:0] blksize_value;
   } req_type;

   typedef struct packed {
      logic [1:0]  send_kind;
      logic [15:0] ack_block;
      logic [15:0] peer_port;
      logic [15:0] our_port;
      logic        store_valid;
      logic [31:0] store_address;
      logic [15:0] store_length;
      logic        rearm_timer;
      logic [1:0]  status;
      logic [31:0] loaded_size;
   } rsp_type;

   typedef enum logic [2:0] {
      CMD_NOP     = 3'd0,
      CMD_START   = 3'd1,
      CMD_OACK    = 3'd2,
      CMD_DATA    = 3'd3,
      CMD_ERROR   = 3'd4,
      CMD_TIMEOUT = 3'd5
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [11:0]  local_port;
      logic [15:0]  dest_port;
      logic [15:0]  src_port;
      logic [15:0]  payload_len;
      logic [15:0]  block_or_code;
      logic         has_blksize;
      logic [15:0]  blksize_value;
      logic         err_fail;
   } cmd_type;

endpackage

`default_nettype wire

// ===== hdl/tcre_front.sv =====
`default_nettype none

module tcre_front
   import tcre_pkg::*;
(
   input  req_type req_data,
   output cmd_type cmd
);

   always_comb begin
      cmd.kind = CMD_NOP;
      cmd.local_port = req_data.local_port;
      cmd.dest_port = req_data.dest_port;
      cmd.src_port = req_data.src_port;
      cmd.payload_len = req_data.udp_len - DATA_HEADER_LEN;
      cmd.block_or_code = req_data.block_or_code;
      cmd.has_blksize = req_data.has_blksize;
      cmd.blksize_value = req_data.blksize_value;
      cmd.err_fail = (req_data.block_or_code == ERR_CODE_NOT_FOUND) ||
                     (req_data.block_or_code == ERR_CODE_ACCESS);
      unique case (req_data.opcode)
         OPCODE_START: begin
            cmd.kind = CMD_START;
         end
         OPCODE_TIMEOUT: begin
            cmd.kind = CMD_TIMEOUT;
         end
         OPCODE_PACKET: begin
            if (req_data.udp_len >= MIN_PACKET_LEN) begin
               unique case (req_data.tftp_op)
                  TFTP_OP_OACK: cmd.kind = CMD_OACK;
                  TFTP_OP_ERROR: cmd.kind = CMD_ERROR;
                  TFTP_OP_DATA: begin
                     if (req_data.udp_len >= DATA_HEADER_LEN) begin
                        cmd.kind = CMD_DATA;
                     end
                  end
                  default: cmd.kind = CMD_NOP;
               endcase
            end
         end
         default: cmd.kind = CMD_NOP;
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/tcre_queue.sv =====
`default_nettype none

module tcre_queue
   import tcre_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type pop_data
);

   cmd_type                    entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0] count_ff, count_in;
   logic                       do_push, do_pop;

   assign full = (count_ff == QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + QUEUE_PTR_WIDTH'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + QUEUE_PTR_WIDTH'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_WIDTH'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/tcre_back.sv =====
`default_nettype none

module tcre_back
   import tcre_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       queue_empty,
   input  cmd_type                    queue_data,
   output logic                       queue_pop,
   input  logic                       csr_valid,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [31:0]                csr_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_type                    rsp_data
);

   typedef enum logic [3:0] {
      MODE_IDLE = 4'b0001,
      MODE_RRQ  = 4'b0010,
      MODE_OACK = 4'b0100,
      MODE_DATA = 4'b1000
   } mode_type;

   typedef enum logic [1:0] {
      SEQ_FETCH = 2'b01,
      SEQ_EXEC  = 2'b10
   } seq_type;

   seq_type     seq_ff, seq_in;
   mode_type    mode_ff, mode_in;
   logic [7:0]  retry_limit_ff;
   logic [31:0] load_base_ff;
   logic [15:0] remote_port_ff, remote_port_in;
   logic [15:0] local_port_ff, local_port_in;
   logic [15:0] current_block_ff, current_block_in;
   logic [15:0] previous_block_ff, previous_block_in;
   logic [31:0] wrap_offset_ff, wrap_offset_in;
   logic [7:0]  retry_count_ff, retry_count_in;
   logic [15:0] block_size_ff, block_size_in;
   logic [31:0] size_loaded_ff, size_loaded_in;

   cmd_type     cmd_ff;
   logic [31:0] prod_ff;
   logic [31:0] wrap_eff_ff, wrap_eff_in;
   logic [31:0] addr_adj_ff, addr_adj_in;
   logic [31:0] size_adj_ff, size_adj_in;
   logic        wrap_hit_ff, wrap_hit_in;

   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;
   rsp_type     result;

   logic        out_free, exec_go, first_block, pass;
   logic [31:0] store_addr, new_size;
   logic [15:0] prev_eff;
   logic [8:0]  retry_next;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign exec_go = (seq_ff == SEQ_EXEC) && out_free;
   assign queue_pop = (seq_ff == SEQ_FETCH) && !queue_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   always_comb begin
      seq_in = seq_ff;
      unique case (seq_ff)
         SEQ_FETCH: if (!queue_empty) seq_in = SEQ_EXEC;
         SEQ_EXEC: if (out_free) seq_in = SEQ_FETCH;
         default: seq_in = SEQ_FETCH;
      endcase
   end

   // First step: block offset terms that do not need the product.
   always_comb begin
      wrap_hit_in = (queue_data.block_or_code == '0) && (previous_block_ff != '0);
      if ((mode_ff == MODE_RRQ) || (mode_ff == MODE_OACK)) begin
         wrap_eff_in = '0;
      end else if (wrap_hit_in) begin
         wrap_eff_in = wrap_offset_ff + {block_size_ff, 16'd0};
      end else begin
         wrap_eff_in = wrap_offset_ff;
      end
      addr_adj_in = wrap_eff_in + load_base_ff - {16'd0, block_size_ff};
      size_adj_in = wrap_eff_in + {16'd0, queue_data.payload_len} -
                    {16'd0, block_size_ff};
   end

   // Second step: the event itself.
   always_comb begin
      store_addr = prod_ff + addr_adj_ff;
      new_size = prod_ff + size_adj_ff;
      first_block = (mode_ff == MODE_RRQ) || (mode_ff == MODE_OACK);
      prev_eff = first_block ? 16'd0 : previous_block_ff;
      retry_next = {1'b0, retry_count_ff} + 9'd1;
      pass = (mode_ff != MODE_IDLE) && (cmd_ff.dest_port == local_port_ff) &&
             ((mode_ff == MODE_RRQ) || (cmd_ff.src_port == remote_port_ff));

      mode_in = mode_ff;
      remote_port_in = remote_port_ff;
      local_port_in = local_port_ff;
      current_block_in = current_block_ff;
      previous_block_in = previous_block_ff;
      wrap_offset_in = wrap_offset_ff;
      retry_count_in = retry_count_ff;
      block_size_in = block_size_ff;
      size_loaded_in = size_loaded_ff;

      result = '0;
      result.send_kind = SEND_NONE;
      result.status = STATUS_RUNNING;

      unique case (cmd_ff.kind)
         CMD_START: begin
            mode_in = MODE_RRQ;
            remote_port_in = SERVER_PORT;
            local_port_in = {4'd0, cmd_ff.local_port};
            retry_count_in = '0;
            current_block_in = '0;
            block_size_in = DEFAULT_BLOCK;
            size_loaded_in = '0;
            result.send_kind = SEND_RRQ;
            result.peer_port = SERVER_PORT;
            result.our_port = {4'd0, cmd_ff.local_port};
            result.rearm_timer = 1'b1;
         end
         CMD_OACK: begin
            if (pass) begin
               mode_in = MODE_OACK;
               remote_port_in = cmd_ff.src_port;
               if (cmd_ff.has_blksize) begin
                  block_size_in = cmd_ff.blksize_value;
               end
               result.send_kind = SEND_ACK;
               result.ack_block = current_block_ff;
               result.peer_port = cmd_ff.src_port;
               result.our_port = local_port_ff;
            end
         end
         CMD_ERROR: begin
            if (pass) begin
               result.status = cmd_ff.err_fail ? STATUS_FAILED : STATUS_RESTART;
               mode_in = MODE_IDLE;
            end
         end
         CMD_DATA: begin
            if (pass) begin
               current_block_in = cmd_ff.block_or_code;
               wrap_offset_in = wrap_eff_ff;
               if (wrap_hit_ff) begin
                  retry_count_in = '0;
               end
               if (first_block) begin
                  mode_in = MODE_DATA;
                  remote_port_in = cmd_ff.src_port;
                  previous_block_in = '0;
               end
               if (first_block && (cmd_ff.block_or_code != 16'd1)) begin
                  result.status = STATUS_RESTART;
                  mode_in = MODE_IDLE;
               end else if (cmd_ff.block_or_code != prev_eff) begin
                  previous_block_in = cmd_ff.block_or_code;
                  result.rearm_timer = 1'b1;
                  result.store_valid = 1'b1;
                  result.store_address = store_addr;
                  result.store_length = cmd_ff.payload_len;
                  if (size_loaded_ff < new_size) begin
                     size_loaded_in = new_size;
                  end
                  result.send_kind = SEND_ACK;
                  result.ack_block = cmd_ff.block_or_code;
                  result.peer_port = remote_port_in;
                  result.our_port = local_port_ff;
                  if (cmd_ff.payload_len < block_size_ff) begin
                     result.status = STATUS_DONE;
                     mode_in = MODE_IDLE;
                  end
               end
            end
         end
         CMD_TIMEOUT: begin
            if (mode_ff != MODE_IDLE) begin
               retry_count_in = retry_next[8] ? 8'hFF : retry_next[7:0];
               if (retry_next > {1'b0, retry_limit_ff}) begin
                  result.status = STATUS_RESTART;
                  mode_in = MODE_IDLE;
               end else begin
                  result.rearm_timer = 1'b1;
                  result.peer_port = remote_port_ff;
                  result.our_port = local_port_ff;
                  if (mode_ff == MODE_RRQ) begin
                     result.send_kind = SEND_RRQ;
                  end else begin
                     result.send_kind = SEND_ACK;
                     result.ack_block = current_block_ff;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      result.loaded_size = size_loaded_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= SEQ_FETCH;
         mode_ff <= MODE_IDLE;
         retry_limit_ff <= DEFAULT_RETRIES;
         load_base_ff <= '0;
         remote_port_ff <= '0;
         local_port_ff <= '0;
         current_block_ff <= '0;
         previous_block_ff <= '0;
         wrap_offset_ff <= '0;
         retry_count_ff <= '0;
         block_size_ff <= DEFAULT_BLOCK;
         size_loaded_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff <= seq_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_RETRY_LIMIT: retry_limit_ff <= csr_data[7:0];
               CSR_LOAD_BASE: load_base_ff <= csr_data;
               default: begin
               end
            endcase
         end
         if (exec_go) begin
            mode_ff <= mode_in;
            remote_port_ff <= remote_port_in;
            local_port_ff <= local_port_in;
            current_block_ff <= current_block_in;
            previous_block_ff <= previous_block_in;
            wrap_offset_ff <= wrap_offset_in;
            retry_count_ff <= retry_count_in;
            block_size_ff <= block_size_in;
            size_loaded_ff <= size_loaded_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         cmd_ff <= queue_data;
         prod_ff <= {16'd0, queue_data.block_or_code} * {16'd0, block_size_ff};
         wrap_eff_ff <= wrap_eff_in;
         addr_adj_ff <= addr_adj_in;
         size_adj_ff <= size_adj_in;
         wrap_hit_ff <= wrap_hit_in;
      end
      if (exec_go) begin
         rsp_data_ff <= result;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/tftp_client_receive_engine.sv =====
// Receive engine of a TFTP read client.
// Requests arrive on the req_ channel (valid/stall) and carry one event each:
// start of a transfer, the decoded header of a received packet, or a timer
// expiry. Every accepted request yields exactly one response on the rsp_
// channel, in order, telling what to send, where to store the payload, whether
// to rearm the timer and the transfer status.
// A front stage classifies each request and places it in a two-entry queue.
// The back end executes each request in a fetch step, which pops it and
// registers the block product and offset terms, and an execute step, which
// updates the transfer state and loads the response register. It pops the
// next request only once the execute step of the last one has completed.
// When rsp_stall is held the response register keeps its contents, the back
// end waits, and req_stall rises once the queue is full.
// The csr_ channel writes retry_limit (index 0) and load_base (index 1); it is
// always ready. Write it only while the engine is quiet; it is not enforced.
// Synchronous reset empties the queue, drops any pending response, sets the
// transfer idle with block size 512 and restores retry_limit 10, load_base 0.
`default_nettype none

module tftp_client_receive_engine
   import tcre_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_type                    rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [31:0]                csr_data
);

   cmd_type front_cmd;
   cmd_type queue_data;
   logic    queue_full, queue_empty, queue_pop;

   assign req_stall = queue_full;
   assign csr_ready = 1'b1;

   tcre_front u_front (
      .req_data (req_data),
      .cmd      (front_cmd)
   );

   tcre_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_data (front_cmd),
      .full      (queue_full),
      .pop       (queue_pop),
      .empty     (queue_empty),
      .pop_data  (queue_data)
   );

   tcre_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_data  (queue_data),
      .queue_pop   (queue_pop),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire
